>>> design/ray_capped_cylinder_intersect_defines.svh
// Assertion macros for the ray versus capped cylinder block.
// Included by the top level; depends on nothing else.
`ifndef RAY_CAPPED_CYLINDER_INTERSECT_DEFINES_SVH
`define RAY_CAPPED_CYLINDER_INTERSECT_DEFINES_SVH

// Same-cycle implication under synchronous active-low reset.
`define RCCI_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under synchronous active-low reset.
`define RCCI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/rcci_pkg.sv
// Shared types, widths, codes and latencies of the ray versus capped cylinder block.
// Used by every module of the block; depends on nothing.
package rcci_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DIST_W    = 31;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } ray_in_t;

  typedef struct packed {
    logic              hit;
    logic [DIST_W-1:0] distance;
    logic [1:0]        hit_part;
  } ray_out_t;

  localparam logic [1:0] PART_NONE = 2'd0;
  localparam logic [1:0] PART_CAP  = 2'd1;
  localparam logic [1:0] PART_NEAR = 2'd2;
  localparam logic [1:0] PART_FAR  = 2'd3;

  localparam logic [2:0] REG_CENTER_X   = 3'd0;
  localparam logic [2:0] REG_CENTER_Y   = 3'd1;
  localparam logic [2:0] REG_CENTER_Z   = 3'd2;
  localparam logic [2:0] REG_RADIUS     = 3'd3;
  localparam logic [2:0] REG_CYL_HEIGHT = 3'd4;

  localparam int SQ_IN_W    = 66;
  localparam int SQ_OUT_W   = 2 * SQ_IN_W;
  localparam int SQRT_OUT_W = 63;
  localparam int SQRT_IN_W  = 2 * SQRT_OUT_W;
  localparam int NUM_MAG_W  = 66;
  localparam int DIV_NUM_W  = NUM_MAG_W + FRAC_BITS;
  localparam int DIV_DEN_W  = 64;
  localparam int QUO_W      = FRAC_BITS + 35;

  localparam int LAT_SQR  = 2;
  localparam int LAT_SQRT = SQRT_OUT_W + 1;
  localparam int LAT_DIV  = QUO_W + 2;
  localparam int LAT_HGT  = 2;

endpackage

>>> design/rcci_sqr.sv
// Two-stage squarer of an unsigned magnitude built from three half-width products.
// Depends on rcci_pkg.
module rcci_sqr import rcci_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  logic [SQ_IN_W-1:0]  x,
  output logic [SQ_OUT_W-1:0] y
);
  localparam int HW = SQ_IN_W / 2;

  logic [2*HW-1:0]     hh_r, hl_r, ll_r;
  logic [SQ_OUT_W-1:0] y_r;

  always_ff @(posedge clk) begin
    if (en) begin
      hh_r <= x[SQ_IN_W-1:HW] * x[SQ_IN_W-1:HW];
      hl_r <= x[SQ_IN_W-1:HW] * x[HW-1:0];
      ll_r <= x[HW-1:0] * x[HW-1:0];
      y_r  <= (SQ_OUT_W'(hh_r) << (2 * HW)) + (SQ_OUT_W'(hl_r) << (HW + 1)) +
              SQ_OUT_W'(ll_r);
    end
  end

  assign y = y_r;
endmodule

>>> design/rcci_isqrt.sv
// Pipelined floor square root, one result bit per register stage.
// Depends on rcci_pkg.
module rcci_isqrt import rcci_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic [SQRT_IN_W-1:0]  rad,
  output logic [SQRT_OUT_W-1:0] root
);
  localparam int RW = SQRT_IN_W + 1;
  localparam int N  = SQRT_OUT_W;

  logic [RW-1:0] rem_r [0:N-1];
  logic [N-1:0]  acc_r [0:N];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= RW'(rad);
      acc_r[0] <= '0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    localparam int B = N - 1 - i;
    logic [RW-1:0] trial;
    logic          take;

    assign trial = ((RW'(acc_r[i]) << 1) | (RW'(1) << B)) << B;
    assign take  = rem_r[i] >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        acc_r[i+1] <= acc_r[i] | (N'(take) << B);
      end
    end

    if (i < N - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i+1] <= take ? rem_r[i] - trial : rem_r[i];
        end
      end
    end
  end

  assign root = acc_r[N];
endmodule

>>> design/rcci_div.sv
// Pipelined restoring divider, one quotient bit per stage, quotient clamped to its top bit.
// Depends on rcci_pkg.
module rcci_div import rcci_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic [QUO_W-1:0]     quo
);
  localparam int CW = DIV_DEN_W + QUO_W;
  localparam logic [QUO_W-1:0] T_CLAMP = QUO_W'(1) << (QUO_W - 1);

  logic [DIV_NUM_W-1:0] rem_r [0:QUO_W-1];
  logic [DIV_DEN_W-1:0] den_r [0:QUO_W-1];
  logic [QUO_W-1:0]     q_r   [0:QUO_W];
  logic                 ovf_r [0:QUO_W];
  logic [QUO_W-1:0]     quo_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num;
      den_r[0] <= den;
      q_r[0]   <= '0;
      ovf_r[0] <= CW'(num) >= {den, {QUO_W{1'b0}}};
      quo_r    <= (ovf_r[QUO_W] || q_r[QUO_W][QUO_W-1]) ? T_CLAMP : q_r[QUO_W];
    end
  end

  for (genvar i = 0; i < QUO_W; i++) begin : g_step
    localparam int B = QUO_W - 1 - i;
    logic [CW-1:0] trial;
    logic          take;

    assign trial = CW'(den_r[i]) << B;
    assign take  = CW'(rem_r[i]) >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[i+1]   <= q_r[i] | (QUO_W'(take) << B);
        ovf_r[i+1] <= ovf_r[i];
      end
    end

    if (i < QUO_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i+1] <= take ? DIV_NUM_W'(CW'(rem_r[i]) - trial) : rem_r[i];
          den_r[i+1] <= den_r[i];
        end
      end
    end
  end

  assign quo = quo_r;
endmodule

>>> design/rcci_hgt.sv
// Two-stage height window test of a hit point along the cylinder axis.
// Depends on rcci_pkg.
module rcci_hgt import rcci_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic [QUO_W-1:0]        t,
  input  logic signed [31:0]      dy,
  input  logic signed [32:0]      ry,
  input  logic [DIST_W-1:0]       h,
  output logic                    ok
);
  localparam int MW = QUO_W + 32;
  localparam int YW = MW + 2;

  logic [63:0]                     p_lo_r;
  logic [QUO_W-1:0]                p_hi_r;
  logic                            neg_r;
  logic signed [32+FRAC_BITS:0]    base_r;
  logic [31:0]                     dya;
  logic [MW-1:0]                   mag;
  logic signed [YW-1:0]            mag_s, base_s, y, top;
  logic                            ok_r;

  assign dya = dy[31] ? 32'(-dy) : 32'(dy);

  always_ff @(posedge clk) begin
    if (en) begin
      p_lo_r <= t[31:0] * dya;
      p_hi_r <= t[QUO_W-1:32] * dya;
      neg_r  <= dy[31];
      base_r <= {ry, {FRAC_BITS{1'b0}}};
      ok_r   <= !y[YW-1] && (y <= top);
    end
  end

  always_comb begin
    mag    = (MW'(p_hi_r) << 32) + MW'(p_lo_r);
    mag_s  = $signed(YW'(mag));
    base_s = YW'(base_r);
    y      = neg_r ? base_s - mag_s : base_s + mag_s;
    top    = $signed(YW'({h, {FRAC_BITS{1'b0}}}));
  end

  assign ok = ok_r;
endmodule

>>> design/ray_capped_cylinder_intersect.sv
// Top level of the ray versus capped vertical cylinder intersection block.
// Depends on rcci_pkg, rcci_sqr, rcci_isqrt, rcci_div, rcci_hgt and the defines header.
//
// The block takes one ray per clock cycle while not stalled and returns exactly one result per ray,
// in order. The latency is set by the 64-stage square root of the side discriminant followed by
// the 53-stage dividers for the ray parameter. All stages move together: while a finished result
// waits on out_stall, the whole pipeline holds and in_stall is raised, so nothing is lost or
// repeated. Configuration must be written only while no ray is in flight.
`include "ray_capped_cylinder_intersect_defines.svh"

module ray_capped_cylinder_intersect import rcci_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  ray_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output ray_out_t    out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  localparam int ST_D   = 7;
  localparam int ST_S   = ST_D + LAT_SQRT;
  localparam int ST_N   = ST_S + 1;
  localparam int ST_T   = ST_N + LAT_DIV;
  localparam int ST_H   = ST_T + LAT_HGT;
  localparam int ST_OUT = ST_H + 1;

  typedef struct packed {
    logic [63:0]        a;
    logic signed [65:0] b;
    logic [32:0]        qa;
    logic [31:0]        dya;
    logic signed [31:0] dy;
    logic signed [32:0] ry;
    logic               cap_ok;
    logic               cap_hit;
    logic               dneg;
  } trk_t;

  typedef struct packed {
    logic signed [31:0] dy;
    logic signed [32:0] ry;
    logic               cap_hit;
    logic               pos1;
    logic               pos2;
  } tail_t;

  function automatic logic [DIST_W-1:0] sat_dist(input logic [QUO_W-1:0] t);
    return (|t[QUO_W-1:DIST_W]) ? {DIST_W{1'b1}} : t[DIST_W-1:0];
  endfunction

  logic signed [31:0]  cx_r, cy_r, cz_r;
  logic [DIST_W-1:0]   rad_r, hgt_r;
  logic                en;
  logic [ST_OUT:1]     vld_r;

  logic signed [32:0]  px1_r, pz1_r, ry1_r;
  logic signed [33:0]  q1_r;
  logic signed [31:0]  dx1_r, dy1_r, dz1_r;
  logic [31:0]         dya1;

  logic signed [64:0]  m_pxdy_r, m_pzdy_r, m_dxpx_r, m_dzpz_r, m_dxpz_r, m_dzpx_r;
  logic signed [65:0]  m_qdx_r, m_qdz_r;
  logic signed [63:0]  m_dxdx_r, m_dzdz_r;
  logic [61:0]         m_rr_r;
  logic [62:0]         m_rdy_r;
  logic [32:0]         qa2_r;
  logic [31:0]         dya2_r;
  logic signed [31:0]  dy2_r;
  logic signed [32:0]  ry2_r;
  logic                cap_ok2_r;

  logic signed [66:0]  xs3_r, zs3_r;
  logic signed [65:0]  cr3_r;
  logic [61:0]         rr3_r;
  logic [62:0]         rdy3_r;
  trk_t                trk_r [3:ST_S];
  trk_t                trk_d;

  logic [SQ_IN_W-1:0]  xsm4_r, zsm4_r, crm4_r, rdym4_r;
  logic [61:0]         pp_hh_r, pp_lh_r;
  logic [63:0]         pp_hl_r, pp_ll_r;
  logic [125:0]        ar5_r, ar6_r;
  logic [SQ_OUT_W-1:0] xs2, zs2, cr2, rdy2;
  logic [SQ_OUT_W:0]   lhs, dfull;

  logic [SQRT_IN_W-1:0]  dval_r;
  logic [SQRT_OUT_W-1:0] s_root;

  logic signed [67:0]  nb, n1, n2;
  logic [NUM_MAG_W-1:0] nm1_r, nm2_r;
  logic [63:0]         a72_r;
  logic [32:0]         qa72_r;
  logic [31:0]         dya72_r;
  tail_t               tail_r [ST_N:ST_H];

  logic [QUO_W-1:0]    t1, t2, tcap, tcap1_r, tcap2_r;
  logic                ok1, ok2;
  ray_out_t            out_r, out_nxt;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r  <= '0;
      cy_r  <= '0;
      cz_r  <= '0;
      rad_r <= DIST_W'(65536);
      hgt_r <= DIST_W'(65536);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTER_X:   cx_r  <= cfg_wdata;
        REG_CENTER_Y:   cy_r  <= cfg_wdata;
        REG_CENTER_Z:   cz_r  <= cfg_wdata;
        REG_RADIUS:     rad_r <= cfg_wdata[DIST_W-1:0];
        REG_CYL_HEIGHT: hgt_r <= cfg_wdata[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  assign en       = !vld_r[ST_OUT] || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[ST_OUT-1:1], in_valid};
    end
  end

  assign dya1 = dy1_r[31] ? 32'(-dy1_r) : 32'(dy1_r);

  // Offsets, products, sums and magnitudes.
  always_ff @(posedge clk) begin
    if (en) begin
      px1_r <= 33'(in_data.origin_x) - 33'(cx_r);
      pz1_r <= 33'(in_data.origin_z) - 33'(cz_r);
      ry1_r <= 33'(in_data.origin_y) - 33'(cy_r);
      q1_r  <= 34'(cy_r) + 34'(hgt_r) - 34'(in_data.origin_y);
      dx1_r <= in_data.dir_x;
      dy1_r <= in_data.dir_y;
      dz1_r <= in_data.dir_z;

      m_pxdy_r  <= px1_r * dy1_r;
      m_pzdy_r  <= pz1_r * dy1_r;
      m_qdx_r   <= q1_r * dx1_r;
      m_qdz_r   <= q1_r * dz1_r;
      m_dxdx_r  <= dx1_r * dx1_r;
      m_dzdz_r  <= dz1_r * dz1_r;
      m_dxpx_r  <= dx1_r * px1_r;
      m_dzpz_r  <= dz1_r * pz1_r;
      m_dxpz_r  <= dx1_r * pz1_r;
      m_dzpx_r  <= dz1_r * px1_r;
      m_rr_r    <= rad_r * rad_r;
      m_rdy_r   <= rad_r * dya1;
      qa2_r     <= 33'(q1_r[33] ? -q1_r : q1_r);
      dya2_r    <= dya1;
      dy2_r     <= dy1_r;
      ry2_r     <= ry1_r;
      cap_ok2_r <= (dy1_r != '0) && (q1_r != '0) && (q1_r[33] == dy1_r[31]);

      xs3_r  <= 67'(m_pxdy_r) + 67'(m_qdx_r);
      zs3_r  <= 67'(m_pzdy_r) + 67'(m_qdz_r);
      cr3_r  <= 66'(m_dxpz_r) - 66'(m_dzpx_r);
      rr3_r  <= m_rr_r;
      rdy3_r <= m_rdy_r;
      trk_r[3].a       <= 64'(m_dxdx_r) + 64'(m_dzdz_r);
      trk_r[3].b       <= 66'(m_dxpx_r) + 66'(m_dzpz_r);
      trk_r[3].qa      <= qa2_r;
      trk_r[3].dya     <= dya2_r;
      trk_r[3].dy      <= dy2_r;
      trk_r[3].ry      <= ry2_r;
      trk_r[3].cap_ok  <= cap_ok2_r;
      trk_r[3].cap_hit <= 1'b0;
      trk_r[3].dneg    <= 1'b0;

      xsm4_r  <= SQ_IN_W'(xs3_r[66] ? -xs3_r : xs3_r);
      zsm4_r  <= SQ_IN_W'(zs3_r[66] ? -zs3_r : zs3_r);
      crm4_r  <= SQ_IN_W'(cr3_r[65] ? -cr3_r : cr3_r);
      rdym4_r <= SQ_IN_W'(rdy3_r);
      pp_hh_r <= trk_r[3].a[63:32] * rr3_r[61:32];
      pp_hl_r <= trk_r[3].a[63:32] * rr3_r[31:0];
      pp_lh_r <= trk_r[3].a[31:0] * rr3_r[61:32];
      pp_ll_r <= trk_r[3].a[31:0] * rr3_r[31:0];

      ar5_r <= (126'(pp_hh_r) << 64) + ((126'(pp_hl_r) + 126'(pp_lh_r)) << 32) +
               126'(pp_ll_r);
      ar6_r <= ar5_r;

      dval_r <= dfull[SQ_OUT_W] ? '0 : dfull[SQRT_IN_W-1:0];

      for (int k = 4; k <= ST_S; k++) begin
        trk_r[k] <= (k == ST_D) ? trk_d : trk_r[k-1];
      end
    end
  end

  rcci_sqr u_sq_xs  (.clk(clk), .en(en), .x(xsm4_r),  .y(xs2));
  rcci_sqr u_sq_zs  (.clk(clk), .en(en), .x(zsm4_r),  .y(zs2));
  rcci_sqr u_sq_cr  (.clk(clk), .en(en), .x(crm4_r),  .y(cr2));
  rcci_sqr u_sq_rdy (.clk(clk), .en(en), .x(rdym4_r), .y(rdy2));

  // Cap disk test and the discriminant a*r^2 - (dx*pz - dz*px)^2.
  always_comb begin
    lhs           = (SQ_OUT_W + 1)'(xs2) + (SQ_OUT_W + 1)'(zs2);
    dfull         = (SQ_OUT_W + 1)'(ar6_r) - (SQ_OUT_W + 1)'(cr2);
    trk_d         = trk_r[ST_D-1];
    trk_d.cap_hit = trk_r[ST_D-1].cap_ok && (lhs <= (SQ_OUT_W + 1)'(rdy2));
    trk_d.dneg    = dfull[SQ_OUT_W];
  end

  rcci_isqrt u_isqrt (.clk(clk), .en(en), .rad(dval_r), .root(s_root));

  always_comb begin
    nb = -68'(trk_r[ST_S].b);
    n1 = nb - 68'(s_root);
    n2 = nb + 68'(s_root);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nm1_r   <= n1[NUM_MAG_W-1:0];
      nm2_r   <= n2[NUM_MAG_W-1:0];
      a72_r   <= trk_r[ST_S].a;
      qa72_r  <= trk_r[ST_S].qa;
      dya72_r <= trk_r[ST_S].dya;
      tail_r[ST_N].dy      <= trk_r[ST_S].dy;
      tail_r[ST_N].ry      <= trk_r[ST_S].ry;
      tail_r[ST_N].cap_hit <= trk_r[ST_S].cap_hit;
      tail_r[ST_N].pos1    <= !trk_r[ST_S].dneg && !n1[67] && (n1 != '0);
      tail_r[ST_N].pos2    <= !trk_r[ST_S].dneg && !n2[67] && (n2 != '0);
      for (int k = ST_N + 1; k <= ST_H; k++) begin
        tail_r[k] <= tail_r[k-1];
      end
      tcap1_r <= tcap;
      tcap2_r <= tcap1_r;
      out_r   <= out_nxt;
    end
  end

  rcci_div u_div_near (
    .clk(clk), .en(en), .num({nm1_r, {FRAC_BITS{1'b0}}}), .den(a72_r), .quo(t1)
  );
  rcci_div u_div_far (
    .clk(clk), .en(en), .num({nm2_r, {FRAC_BITS{1'b0}}}), .den(a72_r), .quo(t2)
  );
  rcci_div u_div_cap (
    .clk(clk), .en(en), .num(DIV_NUM_W'({qa72_r, {FRAC_BITS{1'b0}}})),
    .den(DIV_DEN_W'(dya72_r)), .quo(tcap)
  );

  rcci_hgt u_hgt_near (
    .clk(clk), .en(en), .t(t1), .dy(tail_r[ST_T].dy), .ry(tail_r[ST_T].ry), .h(hgt_r),
    .ok(ok1)
  );
  rcci_hgt u_hgt_far (
    .clk(clk), .en(en), .t(t2), .dy(tail_r[ST_T].dy), .ry(tail_r[ST_T].ry), .h(hgt_r),
    .ok(ok2)
  );

  logic [QUO_W-1:0] t1_d1_r, t1_d2_r, t2_d1_r, t2_d2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      t1_d1_r <= t1;
      t1_d2_r <= t1_d1_r;
      t2_d1_r <= t2;
      t2_d2_r <= t2_d1_r;
    end
  end

  always_comb begin
    out_nxt = '0;
    out_nxt.hit_part = PART_NONE;
    if (tail_r[ST_H].cap_hit) begin
      out_nxt.hit      = 1'b1;
      out_nxt.distance = sat_dist(tcap2_r);
      out_nxt.hit_part = PART_CAP;
    end else if (tail_r[ST_H].pos1 && ok1) begin
      out_nxt.hit      = 1'b1;
      out_nxt.distance = sat_dist(t1_d2_r);
      out_nxt.hit_part = PART_NEAR;
    end else if (tail_r[ST_H].pos2 && ok2) begin
      out_nxt.hit      = 1'b1;
      out_nxt.distance = sat_dist(t2_d2_r);
      out_nxt.hit_part = PART_FAR;
    end
  end

  assign out_valid = vld_r[ST_OUT];
  assign out_data  = out_r;

  `RCCI_ASSERT_IMPLY(a_miss_clean, clk, rst_n, out_valid && !out_data.hit, out_data.hit_part == PART_NONE && out_data.distance == '0, "miss result carries a part or distance")
  `RCCI_ASSERT_IMPLY(a_hit_part, clk, rst_n, out_valid && out_data.hit, out_data.hit_part != PART_NONE, "hit result without a part")
  `RCCI_ASSERT_IMPLY(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall, "input stalled without a held result")
  `RCCI_ASSERT_NEXT(a_advance, clk, rst_n, vld_r[ST_OUT-1] && !in_stall, out_valid, "pipeline advance lost a transfer")

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for ray_capped_cylinder_intersect: directed rays and then random rays,
// over several cylinder settings, with random idle cycles on both channels.
// Depends on rcci_pkg and the block's RTL; expected results are typed rows or a local predictor.
`timescale 1ns / 1ps

module tb_top;
  import rcci_pkg::*;

  typedef logic signed [255:0] wint_t;

  typedef struct {
    ray_in_t  ray;
    bit       typed;
    ray_out_t want;
  } ray_row_t;

  localparam int              ONE        = 65536;
  localparam logic [2:0]      REG_UNUSED = 3'd7;
  localparam logic [DIST_W-1:0] DIST_SAT = '1;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  ray_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  ray_out_t    out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  logic signed [31:0] cyl_cx, cyl_cy, cyl_cz;
  logic [30:0]        cyl_radius, cyl_h;

  ray_out_t pending_hits[$];
  int       errors = 0;
  int       rays_sent = 0;
  int       results_checked = 0;
  int       settings_used = 1;
  bit       gap_on = 1'b0;
  bit       stall_on = 1'b0;
  int       stall_hold = 0;

  ray_capped_cylinder_intersect uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  initial begin
    #8_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  function automatic wint_t isqrt_floor(wint_t v);
    wint_t root = 0;
    wint_t bitv = wint_t'(1) <<< 252;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic [DIST_W-1:0] clamp_dist(wint_t t);
    if (t > wint_t'(DIST_SAT)) return DIST_SAT;
    return t[DIST_W-1:0];
  endfunction

  function automatic ray_out_t predict_hit(ray_in_t r);
    wint_t one = wint_t'(1) <<< FRAC_BITS;
    wint_t tmax = wint_t'(1) <<< 62;
    wint_t dx = wint_t'(r.dir_x);
    wint_t dy = wint_t'(r.dir_y);
    wint_t dz = wint_t'(r.dir_z);
    wint_t px = wint_t'(r.origin_x) - wint_t'(cyl_cx);
    wint_t pz = wint_t'(r.origin_z) - wint_t'(cyl_cz);
    wint_t rr = wint_t'(cyl_radius);
    wint_t hh = wint_t'(cyl_h);
    wint_t q = wint_t'(cyl_cy) + hh - wint_t'(r.origin_y);
    wint_t ry = wint_t'(r.origin_y) - wint_t'(cyl_cy);
    wint_t xs, zs, rdy, a, b, c, d, s, n, t, y;
    ray_out_t res = '0;
    if (dy != 0 && q != 0 && ((q < 0) == (dy < 0))) begin
      xs = px * dy + q * dx;
      zs = pz * dy + q * dz;
      rdy = rr * dy;
      if (xs * xs + zs * zs <= rdy * rdy) begin
        t = ((q < 0) ? -q : q) * one / ((dy < 0) ? -dy : dy);
        res.hit = 1'b1;
        res.distance = clamp_dist(t);
        res.hit_part = PART_CAP;
        return res;
      end
    end
    a = dx * dx + dz * dz;
    if (a == 0) return res;
    b = dx * px + dz * pz;
    c = px * px + pz * pz - rr * rr;
    d = b * b - a * c;
    if (d < 0) return res;
    s = isqrt_floor(d);
    for (int k = 0; k < 2; k++) begin
      n = (k == 0) ? -b - s : -b + s;
      if (n > 0) begin
        t = n * one / a;
        if (t > tmax) t = tmax;
        y = ry * one + t * dy;
        if (y >= 0 && y <= hh * one) begin
          res.hit = 1'b1;
          res.distance = clamp_dist(t);
          res.hit_part = (k == 0) ? PART_NEAR : PART_FAR;
          return res;
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_hits.size() == 0) begin
        $error("result transfer with no ray outstanding");
        errors++;
      end else begin
        ray_out_t exp_r;
        exp_r = pending_hits.pop_front();
        results_checked++;
        if (out_data.hit !== exp_r.hit) begin
          $error("hit: expected %0d, got %0d", exp_r.hit, out_data.hit);
          errors++;
        end
        if (out_data.distance !== exp_r.distance) begin
          $error("distance: expected %0d, got %0d", exp_r.distance, out_data.distance);
          errors++;
        end
        if (out_data.hit_part !== exp_r.hit_part) begin
          $error("hit_part: expected %0d, got %0d", exp_r.hit_part, out_data.hit_part);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      out_stall <= stall_on && ($urandom_range(0, 3) == 0);
      stall_hold <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 50) : $urandom_range(0, 2);
    end
  end

  task automatic send_ray(ray_in_t r, bit typed, ray_out_t want);
    int gap;
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    pending_hits.push_back(typed ? want : predict_hit(r));
    rays_sent++;
    if (gap_on && $urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_all();
    in_valid <= 1'b0;
    wait (pending_hits.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_cylinder(logic signed [31:0] cx, logic signed [31:0] cy,
                               logic signed [31:0] cz, logic [30:0] rad, logic [30:0] h);
    logic [2:0]  idx[6];
    logic [31:0] val[6];
    idx = '{REG_CENTER_X, REG_CENTER_Y, REG_CENTER_Z, REG_RADIUS, REG_CYL_HEIGHT, REG_UNUSED};
    val = '{cx, cy, cz, {1'b0, rad}, {1'b0, h}, $urandom};
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cyl_cx = cx;
    cyl_cy = cy;
    cyl_cz = cz;
    cyl_radius = rad;
    cyl_h = h;
    settings_used++;
    @(posedge clk);
  endtask

  function automatic ray_in_t mk_ray(int ox, int oy, int oz, int dx, int dy, int dz);
    ray_in_t r;
    r.origin_x = ox;
    r.origin_y = oy;
    r.origin_z = oz;
    r.dir_x = dx;
    r.dir_y = dy;
    r.dir_z = dz;
    return r;
  endfunction

  function automatic ray_out_t mk_res(bit h, logic [DIST_W-1:0] dist_v, logic [1:0] part);
    ray_out_t o;
    o.hit = h;
    o.distance = dist_v;
    o.hit_part = part;
    return o;
  endfunction

  function automatic logic signed [31:0] rnd_scaled();
    return $signed($urandom) >>> $urandom_range(0, 24);
  endfunction

  function automatic ray_in_t rnd_ray();
    ray_in_t r;
    longint lr, lh, tx, ty, tz, ox, oy, oz;
    if ($urandom_range(0, 7) == 0) begin
      r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      return r;
    end
    lr = longint'(cyl_radius) * 3 / 2;
    lh = longint'(cyl_h) * 3 / 2;
    tx = longint'(cyl_cx) + (longint'($urandom) % (2 * lr + 1)) - lr;
    ty = longint'(cyl_cy) + (longint'($urandom) % (lh + 1));
    tz = longint'(cyl_cz) + (longint'($urandom) % (2 * lr + 1)) - lr;
    ox = longint'(rnd_scaled());
    oy = longint'(rnd_scaled());
    oz = longint'(rnd_scaled());
    r.origin_x = 32'(tx + ox);
    r.origin_y = 32'(ty + oy);
    r.origin_z = 32'(tz + oz);
    r.dir_x = 32'(-(ox >>> $urandom_range(0, 4)));
    r.dir_y = 32'(-(oy >>> $urandom_range(0, 4)));
    r.dir_z = 32'(-(oz >>> $urandom_range(0, 4)));
    case ($urandom_range(0, 9))
      0: r.dir_y = '0;
      1: begin
        r.dir_x = '0;
        r.dir_z = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  initial begin
    ray_row_t rows[$];
    ray_out_t miss;
    cyl_cx = 0;
    cyl_cy = 0;
    cyl_cz = 0;
    cyl_radius = 31'(ONE);
    cyl_h = 31'(ONE);
    miss = mk_res(1'b0, '0, PART_NONE);
    rows = '{
      '{mk_ray(0, 2*ONE, 0, 0, -ONE, 0), 1, mk_res(1'b1, 31'(ONE), PART_CAP)},
      '{mk_ray(0, -ONE, 0, 0, ONE, 0), 1, mk_res(1'b1, 31'(2*ONE), PART_CAP)},
      '{mk_ray(0, 2*ONE, 0, 0, ONE, 0), 1, miss},
      '{mk_ray(0, 0, 0, 0, 0, 0), 1, miss},
      '{mk_ray(3*ONE, ONE/2, 0, -ONE, 0, 0), 1, mk_res(1'b1, 31'(2*ONE), PART_NEAR)},
      '{mk_ray(0, ONE/2, 0, ONE, 0, 0), 1, mk_res(1'b1, 31'(ONE), PART_FAR)},
      '{mk_ray(3*ONE, 5*ONE, 0, -ONE, 0, 0), 1, miss},
      '{mk_ray(3*ONE, ONE/2, 3*ONE, -ONE, 0, 0), 1, miss},
      '{mk_ray(0, 32'sh8000_0000, 0, 0, 1, 0), 1, mk_res(1'b1, DIST_SAT, PART_CAP)},
      '{mk_ray(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
               32'sh7FFF_FFFF, 32'sh7FFF_FFFF), 0, miss},
      '{mk_ray(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
               32'sh8000_0000, 32'sh8000_0000), 0, miss},
      '{mk_ray(0, 0, 0, 32'sh7FFF_FFFF, 0, 32'sh8000_0000), 0, miss},
      '{mk_ray(-3*ONE, ONE/2, ONE, ONE, 0, 0), 0, miss},
      '{mk_ray(ONE/2, 3*ONE, 0, -ONE/10, -ONE, ONE/5), 0, miss},
      '{mk_ray(2*ONE, 3*ONE/2, 0, -ONE, -ONE/2, 0), 0, miss},
      '{mk_ray(2*ONE, -ONE, 0, -ONE, 0, ONE/3), 0, miss},
      '{mk_ray(5*ONE, ONE/2, 0, -1, 0, 0), 0, miss},
      '{mk_ray(0, ONE/2, 0, 1, -1, 1), 0, miss},
      '{mk_ray(-ONE, 0, -ONE, ONE, ONE, ONE), 0, miss}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_ray(rows[i].ray, rows[i].typed, rows[i].want);

    for (int ph = 0; ph < 8; ph++) begin
      drain_all();
      case (ph)
        0: ;
        1: load_cylinder(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, '1, '1);
        2: load_cylinder(0, 0, 0, '0, '0);
        3: load_cylinder(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'(ONE), '1);
        default: load_cylinder(rnd_scaled(), rnd_scaled(), rnd_scaled(),
                               31'($urandom_range(1, 1 << 22)), 31'($urandom_range(1, 1 << 22)));
      endcase
      gap_on = (ph % 3) != 0;
      stall_on = (ph % 4) != 1;
      for (int k = 0; k < 118; k++) begin
        if (ph == 5 && k == 60) begin
          in_valid <= 1'b0;
          wait (pending_hits.size() == 0);
          @(posedge clk);
        end
        send_ray(rnd_ray(), 1'b0, miss);
      end
    end

    in_valid <= 1'b0;
    wait (pending_hits.size() == 0);
    repeat (140) @(posedge clk);
    $display("Sent %0d rays over %0d cylinder settings; %0d results compared.",
             rays_sent, settings_used, results_checked);
    if (errors == 0 && pending_hits.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/rcci_pkg.sv
design/rcci_sqr.sv
design/rcci_isqrt.sv
design/rcci_div.sv
design/rcci_hgt.sv
design/ray_capped_cylinder_intersect.sv
sim/tb_top.sv
